[hdl/pwmdf_pkg.sv]
`timescale 1ns / 1ps
package pwmdf_pkg;

  localparam int DEFAULT_FIFO_DEPTH = 512;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE   = 2'd0,
    CFG_CHANNELS = 2'd1,
    CFG_VOLUME   = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_OFF   = 2'd2,
    ST_UNDER = 2'd3
  } status_t;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  localparam logic [1:0] CHANNELS_STEREO = 2'd2;
  localparam logic [6:0] VOLUME_MAX      = 7'd100;
  localparam logic [7:0] DUTY_MID        = 8'd128;
  localparam logic [7:0] DUTY_NONE       = 8'd0;
  localparam logic [16:0] DUTY_OFFSET    = 17'd32768;

  // floor(m / 100) == (m * RECIP_K) >> RECIP_SHIFT for m below 2^22
  localparam int          RECIP_SHIFT = 29;
  localparam logic [22:0] RECIP_K     = 23'd5368710;

  typedef struct packed {
    logic       stereo;
    logic [6:0] volume;
  } cfg_t;

endpackage

[hdl/pwmdf_in_if.sv]
`timescale 1ns / 1ps
interface pwmdf_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;

  modport source (output valid, req_type, left_sample, right_sample, input ready);
  modport sink   (input valid, req_type, left_sample, right_sample, output ready);
endinterface

[hdl/pwmdf_out_if.sv]
`timescale 1ns / 1ps
interface pwmdf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] duty;
  logic       duty_valid;
  logic [1:0] status;
  logic [9:0] fifo_level;

  modport source (output valid, duty, duty_valid, status, fifo_level, input ready);
  modport sink   (input valid, duty, duty_valid, status, fifo_level, output ready);
endinterface

[hdl/pwmdf_duty_pipe.sv]
`timescale 1ns / 1ps
module pwmdf_duty_pipe (
  input  logic               clk,
  input  logic               adv,
  input  pwmdf_pkg::cfg_t    cfg,
  input  logic signed [15:0] left_sample,
  input  logic signed [15:0] right_sample,
  output logic [7:0]         duty
);
  import pwmdf_pkg::*;

  logic signed [16:0] sum_w;
  logic signed [16:0] half_w;
  logic signed [16:0] mono_w;
  logic signed [23:0] mono_ext_w;
  logic signed [23:0] vol_ext_w;
  logic [6:0]         vol_sat_w;
  logic signed [23:0] prod_w;
  logic signed [23:0] prod_r;
  logic [23:0]        mag_w;
  logic [44:0]        recip_w;
  logic [15:0]        quot_r;
  logic               neg_r;
  logic [16:0]        biased_w;

  // stage 1: average toward zero (stereo) or take left, scale by volume
  always_comb begin
    sum_w      = {left_sample[15], left_sample} + {right_sample[15], right_sample};
    half_w     = $signed(sum_w + {16'd0, sum_w[16]}) >>> 1;
    mono_w     = cfg.stereo ? half_w : {left_sample[15], left_sample};
    vol_sat_w  = (cfg.volume > VOLUME_MAX) ? VOLUME_MAX : cfg.volume;
    mono_ext_w = {{7{mono_w[16]}}, mono_w};
    vol_ext_w  = $signed({17'd0, vol_sat_w});
    prod_w     = mono_ext_w * vol_ext_w;
  end

  // stage 2: magnitude divided by 100 through the reciprocal
  always_comb begin
    mag_w   = prod_r[23] ? -prod_r : prod_r;
    recip_w = {23'd0, mag_w[21:0]} * {22'd0, RECIP_K};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= prod_w;
      quot_r <= recip_w[RECIP_SHIFT +: 16];
      neg_r  <= prod_r[23];
    end
  end

  // restore sign, offset, keep top byte
  always_comb begin
    biased_w = neg_r ? (DUTY_OFFSET - {1'b0, quot_r}) : (DUTY_OFFSET + {1'b0, quot_r});
    duty     = biased_w[15:8];
  end

endmodule

[hdl/pwmdf_ram.sv]
`timescale 1ns / 1ps
module pwmdf_ram #(
  parameter int DEPTH = 512,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic          re,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

[hdl/pcm_to_pwm_duty_fifo.sv]
`timescale 1ns / 1ps
// PCM to 8-bit PWM duty converter with a RAM-backed duty FIFO. Every input beat
// is either an audio frame (req_type 0) or a sample-rate tick (req_type 1) and
// produces exactly one result beat, in order. A frame is averaged to mono when
// channel_count is 2, scaled by volume_percent/100 (clamped at 100, truncated
// toward zero), offset by 32768 and cut to its top byte, then pushed into the
// FIFO; a tick pops one duty, or returns 128 when the FIFO is empty or the
// block is disabled. A frame arriving at a full FIFO or while disabled is
// dropped and flagged in status. The block takes one beat per clock; results
// appear from the last stage register, and the whole pipeline holds while a
// result waits on the output. Level, status and FIFO pointers are settled at
// acceptance, the duty arithmetic runs over two register stages (one small
// scale multiply, one reciprocal multiply for the divide by 100), and the RAM
// is written or read, one access per cycle, as the beat leaves the second
// stage. Because all beats move in order, a tick never reads an entry whose
// write is still in flight. Disabling the block leaves queued duties in place.
// Write configuration only while no beat is in flight.
module pcm_to_pwm_duty_fifo #(
  parameter int FIFO_DEPTH = pwmdf_pkg::DEFAULT_FIFO_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  pwmdf_in_if.sink                       in_ch,
  pwmdf_out_if.source                    out_ch,
  input  logic                           cfg_we,
  input  logic [pwmdf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pwmdf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pwmdf_pkg::*;

  localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(FIFO_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(FIFO_DEPTH);

  // configuration registers
  logic       enable_r;
  logic [1:0] channels_r;
  logic [6:0] volume_r;
  cfg_t       cfg;

  // FIFO bookkeeping
  logic [AW-1:0] widx_r, widx_nxt;
  logic [AW-1:0] ridx_r, ridx_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW+9:0] lvl_ext;

  // stage control
  logic          adv, acc, is_wr, push, pop;
  status_t       st_nxt;
  logic          v1_r, v2_r, v3_r;
  logic          tick1_r, tick2_r, tick3_r;
  status_t       st1_r, st2_r, st3_r;
  logic [9:0]    lvl1_r, lvl2_r, lvl3_r;
  logic [AW-1:0] addr1_r, addr2_r;
  logic          ram_we, ram_re;
  logic [7:0]    duty_w, rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= 1'b0;
      channels_r <= 2'd1;
      volume_r   <= VOLUME_MAX;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENABLE:   enable_r   <= cfg_wdata[0];
        CFG_CHANNELS: channels_r <= cfg_wdata[1:0];
        CFG_VOLUME:   volume_r   <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  assign cfg.stereo = (channels_r == CHANNELS_STEREO);
  assign cfg.volume = volume_r;

  // advance every stage together whenever the output slot is free
  assign adv          = !v3_r || out_ch.ready;
  assign in_ch.ready  = adv;
  assign acc          = in_ch.valid && adv;
  assign is_wr        = (in_ch.req_type == REQ_WRITE);

  always_comb begin
    push     = 1'b0;
    pop      = 1'b0;
    st_nxt   = ST_OK;
    priority if (!enable_r) begin
      st_nxt = ST_OFF;
    end else if (is_wr) begin
      if (cnt_r == FULL_CNT) begin
        st_nxt = ST_FULL;
      end else begin
        push = acc;
      end
    end else begin
      if (cnt_r == '0) begin
        st_nxt = ST_UNDER;
      end else begin
        pop = acc;
      end
    end

    widx_nxt = widx_r;
    ridx_nxt = ridx_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      widx_nxt = (widx_r == LAST_IDX) ? '0 : widx_r + 1'b1;
      cnt_nxt  = cnt_r + 1'b1;
    end
    if (pop) begin
      ridx_nxt = (ridx_r == LAST_IDX) ? '0 : ridx_r + 1'b1;
      cnt_nxt  = cnt_r - 1'b1;
    end
    lvl_ext = {10'd0, cnt_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      widx_r <= '0;
      ridx_r <= '0;
      cnt_r  <= '0;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
    end else if (adv) begin
      widx_r <= widx_nxt;
      ridx_r <= ridx_nxt;
      cnt_r  <= cnt_nxt;
      v1_r   <= acc;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
    end
  end

  // payload of each stage; stalls hold it
  always_ff @(posedge clk) begin
    if (adv) begin
      tick1_r <= !is_wr;
      st1_r   <= st_nxt;
      lvl1_r  <= lvl_ext[9:0];
      addr1_r <= is_wr ? widx_r : ridx_r;
      tick2_r <= tick1_r;
      st2_r   <= st1_r;
      lvl2_r  <= lvl1_r;
      addr2_r <= addr1_r;
      tick3_r <= tick2_r;
      st3_r   <= st2_r;
      lvl3_r  <= lvl2_r;
    end
  end

  pwmdf_duty_pipe u_pipe (
    .clk          (clk),
    .adv          (adv),
    .cfg          (cfg),
    .left_sample  (in_ch.left_sample),
    .right_sample (in_ch.right_sample),
    .duty         (duty_w)
  );

  // push writes, pop reads: one RAM access as the beat leaves stage two
  assign ram_we = adv && v2_r && !tick2_r && (st2_r == ST_OK);
  assign ram_re = adv && v2_r &&  tick2_r && (st2_r == ST_OK);

  pwmdf_ram #(
    .DEPTH (FIFO_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (addr2_r),
    .wdata (duty_w),
    .rdata (rdata)
  );

  always_comb begin
    out_ch.valid      = v3_r;
    out_ch.duty_valid = tick3_r;
    out_ch.status     = st3_r;
    out_ch.fifo_level = lvl3_r;
    if (!tick3_r) begin
      out_ch.duty = DUTY_NONE;
    end else if (st3_r == ST_OK) begin
      out_ch.duty = rdata;
    end else begin
      out_ch.duty = DUTY_MID;
    end
  end

endmodule
